[rtl/swds_pkg.sv]
// ----------------------------------------------------------------------------
// swds_pkg
// Shared widths, command codes and status codes for the 64-bit word stack.
// ----------------------------------------------------------------------------
package swds_pkg;

  localparam int unsigned WORD_W      = 64;
  localparam int unsigned OPCODE_W    = 3;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned DEPTH_OUT_W = 8;

  localparam int unsigned STACK_DEPTH_DEFAULT = 128;

  localparam logic [OPCODE_W-1:0] OP_PUSH  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_POP   = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_PEEK  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_DUP   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_SWAP  = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NODUP = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOSWP = 3'd4;

endpackage

[rtl/swds_ram.sv]
// ----------------------------------------------------------------------------
// swds_ram
// Single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module swds_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/stack_with_dup_swap.sv]
// ----------------------------------------------------------------------------
// stack_with_dup_swap
// Last-in first-out stack of 64-bit words with push, pop, peek, duplicate,
// swap and clear commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Every command gives
// exactly one result item, shown on the out_ ports for a single cycle while
// out_valid is high; the receiver cannot stall, so it must capture the item
// in that cycle. Push, peek, duplicate, clear, refused commands and a pop
// that empties the stack keep busy low. A pop that leaves entries behind
// and a successful swap raise busy and pass through the fetch state, because
// the new top of stack must be fetched from the single-port word memory,
// whose read port is registered. The topmost word is kept in a register
// so that it never needs a memory read; the memory holds the words below it.
// Words are opaque bits; unused opcodes return status ok, a zero read value
// and an unchanged depth. out_depth reports the entry count modulo 256.
// ----------------------------------------------------------------------------
module stack_with_dup_swap #(
  parameter int unsigned STACK_DEPTH = swds_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [swds_pkg::OPCODE_W-1:0]    in_opcode,
  input  logic [swds_pkg::WORD_W-1:0]      in_push_value,
  output logic                             out_valid,
  output logic [swds_pkg::WORD_W-1:0]      out_read_value,
  output logic [swds_pkg::STATUS_W-1:0]    out_status,
  output logic [swds_pkg::DEPTH_OUT_W-1:0] out_depth
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned PW = $clog2(STACK_DEPTH + 1);

  // Sequencer states: idle takes commands, fetch waits for the memory read.
  localparam logic S_IDLE  = 1'b0;
  localparam logic S_FETCH = 1'b1;

  logic                             state_r, state_nxt;
  logic [PW-1:0]                    ptr_r, ptr_nxt;
  logic [swds_pkg::WORD_W-1:0]      top_r, top_nxt;
  logic                             swap_r, swap_nxt;
  logic [AW-1:0]                    swap_addr_r, swap_addr_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [swds_pkg::WORD_W-1:0]      out_value_r, out_value_nxt;
  logic [swds_pkg::STATUS_W-1:0]    out_status_r, out_status_nxt;
  logic [swds_pkg::DEPTH_OUT_W-1:0] out_depth_r, out_depth_nxt;

  logic                             ram_we;
  logic [AW-1:0]                    ram_addr;
  logic [swds_pkg::WORD_W-1:0]      ram_wdata;
  logic [swds_pkg::WORD_W-1:0]      ram_rdata;

  logic [PW-1:0] ptr_m1;
  logic [PW-1:0] ptr_m2;
  logic          is_empty;
  logic          is_full;
  logic          has_two;

  assign ptr_m1   = ptr_r - PW'(1);
  assign ptr_m2   = ptr_r - PW'(2);
  assign is_empty = (ptr_r == '0);
  assign is_full  = (ptr_r == PW'(STACK_DEPTH));
  assign has_two  = (ptr_r > PW'(1));

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_status     = out_status_r;
  assign out_depth      = out_depth_r;

  // Entry n-1 is the cached top; spilling it to memory makes room for a new
  // top. Swap and multi-entry pop read entry n-2, which becomes the new top.
  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    top_nxt        = top_r;
    swap_nxt       = swap_r;
    swap_addr_nxt  = swap_addr_r;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = '0;
    out_status_nxt = swds_pkg::ST_OK;
    out_depth_nxt  = out_depth_r;
    ram_we         = 1'b0;
    ram_addr       = ptr_m1[AW-1:0];
    ram_wdata      = top_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          out_valid_nxt = 1'b1;
          case (in_opcode)
            swds_pkg::OP_PUSH: begin
              if (is_full) begin
                out_status_nxt = swds_pkg::ST_FULL;
              end else begin
                ram_we  = !is_empty;
                top_nxt = in_push_value;
                ptr_nxt = ptr_r + PW'(1);
              end
            end
            swds_pkg::OP_POP: begin
              if (is_empty) begin
                out_status_nxt = swds_pkg::ST_EMPTY;
              end else begin
                out_value_nxt = top_r;
                ptr_nxt       = ptr_m1;
                if (has_two) begin
                  ram_addr  = ptr_m2[AW-1:0];
                  swap_nxt  = 1'b0;
                  state_nxt = S_FETCH;
                end
              end
            end
            swds_pkg::OP_PEEK: begin
              if (is_empty) begin
                out_status_nxt = swds_pkg::ST_EMPTY;
              end else begin
                out_value_nxt = top_r;
              end
            end
            swds_pkg::OP_DUP: begin
              if (is_empty || is_full) begin
                out_status_nxt = swds_pkg::ST_NODUP;
              end else begin
                ram_we  = 1'b1;
                ptr_nxt = ptr_r + PW'(1);
              end
            end
            swds_pkg::OP_SWAP: begin
              if (!has_two) begin
                out_status_nxt = swds_pkg::ST_NOSWP;
              end else begin
                // The result goes out once the exchange completes.
                out_valid_nxt = 1'b0;
                ram_addr      = ptr_m2[AW-1:0];
                swap_nxt      = 1'b1;
                swap_addr_nxt = ptr_m2[AW-1:0];
                state_nxt     = S_FETCH;
              end
            end
            swds_pkg::OP_CLEAR: begin
              ptr_nxt = '0;
            end
            default: begin
            end
          endcase
          out_depth_nxt = swds_pkg::DEPTH_OUT_W'(ptr_nxt);
        end
      end
      S_FETCH: begin
        top_nxt   = ram_rdata;
        state_nxt = S_IDLE;
        if (swap_r) begin
          ram_we        = 1'b1;
          ram_addr      = swap_addr_r;
          ram_wdata     = top_r;
          out_valid_nxt = 1'b1;
          out_depth_nxt = swds_pkg::DEPTH_OUT_W'(ptr_r);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
      swap_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
      swap_r      <= swap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r        <= top_nxt;
    swap_addr_r  <= swap_addr_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_depth_r  <= out_depth_nxt;
  end

  swds_ram #(
    .WIDTH (swds_pkg::WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

[verif/stack_with_dup_swap_test.sv]
// ----------------------------------------------------------------------------
// stack_with_dup_swap_test
// Self-checking bench for the 64-bit word stack: commands go in through the
// start/busy handshake, a behavioral stack predicts each result item, and
// every out_valid item is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module stack_with_dup_swap_test;

  // The block is built at its default capacity; the bench keeps its own copy
  // of that number so the full-stack cases can be aimed at exactly.
  localparam int unsigned CAPACITY = swds_pkg::STACK_DEPTH_DEFAULT;

  // Opcodes 6 and 7 carry no command; the block must answer them with a
  // plain ok and leave the stack alone.
  localparam logic [swds_pkg::OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [swds_pkg::OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

  // Generous bound on the whole run of roughly 1400 items plus the pauses.
  localparam int unsigned CYCLE_LIMIT = 200000;

  // One result item as the block reports it.
  typedef struct packed {
    logic [swds_pkg::WORD_W-1:0]      word;
    logic [swds_pkg::STATUS_W-1:0]    status;
    logic [swds_pkg::DEPTH_OUT_W-1:0] depth;
  } stack_reply_t;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             start;
  logic                             busy;
  logic [swds_pkg::OPCODE_W-1:0]    in_opcode;
  logic [swds_pkg::WORD_W-1:0]      in_push_value;
  logic                             out_valid;
  logic [swds_pkg::WORD_W-1:0]      out_read_value;
  logic [swds_pkg::STATUS_W-1:0]    out_status;
  logic [swds_pkg::DEPTH_OUT_W-1:0] out_depth;

  // Shadow copy of the stack: the stored words and the entry count.
  logic [swds_pkg::WORD_W-1:0] stored_words [CAPACITY];
  int unsigned                 stored_count;

  // Replies that have been predicted but not yet seen on the out_ ports.
  stack_reply_t pending_replies [$];

  int unsigned error_count;
  int unsigned reply_count;
  int unsigned cycle_count;
  bit          idle_on;

  stack_with_dup_swap #(
    .STACK_DEPTH(CAPACITY)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_opcode     (in_opcode),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_read_value(out_read_value),
    .out_status    (out_status),
    .out_depth     (out_depth)
  );

  // 12-unit clock period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: if the run has not wrapped up well before this, something in
  // the handshake is stuck and the run is declared failed.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("stack_with_dup_swap: mismatch");
      $finish;
    end
  end

  // Prints one line per discrepancy and keeps the tally for the verdict.
  task automatic report_mismatch(input string what,
                                 input logic [swds_pkg::WORD_W-1:0] got,
                                 input logic [swds_pkg::WORD_W-1:0] want);
    $display("reply %0d: %s is %h, expected %h", reply_count, what, got, want);
    error_count++;
  endtask

  // Applies one command to the shadow stack and returns the reply the block
  // should give. A refused command leaves the shadow untouched; clear only
  // drops the count, so the old words stay in place below it.
  function automatic stack_reply_t apply_command(input logic [swds_pkg::OPCODE_W-1:0] op,
                                                 input logic [swds_pkg::WORD_W-1:0] word);
    stack_reply_t reply;
    logic [swds_pkg::WORD_W-1:0] held;
    reply.word   = '0;
    reply.status = swds_pkg::ST_OK;
    case (op)
      swds_pkg::OP_PUSH: begin
        if (stored_count < CAPACITY) begin
          stored_words[stored_count] = word;
          stored_count++;
        end else begin
          reply.status = swds_pkg::ST_FULL;
        end
      end
      swds_pkg::OP_POP: begin
        if (stored_count > 0) begin
          stored_count--;
          reply.word = stored_words[stored_count];
        end else begin
          reply.status = swds_pkg::ST_EMPTY;
        end
      end
      swds_pkg::OP_PEEK: begin
        if (stored_count > 0) begin
          reply.word = stored_words[stored_count-1];
        end else begin
          reply.status = swds_pkg::ST_EMPTY;
        end
      end
      swds_pkg::OP_DUP: begin
        if (stored_count > 0 && stored_count < CAPACITY) begin
          stored_words[stored_count] = stored_words[stored_count-1];
          stored_count++;
        end else begin
          reply.status = swds_pkg::ST_NODUP;
        end
      end
      swds_pkg::OP_SWAP: begin
        if (stored_count > 1) begin
          held                         = stored_words[stored_count-1];
          stored_words[stored_count-1] = stored_words[stored_count-2];
          stored_words[stored_count-2] = held;
        end else begin
          reply.status = swds_pkg::ST_NOSWP;
        end
      end
      swds_pkg::OP_CLEAR: begin
        stored_count = 0;
      end
      default: begin
      end
    endcase
    reply.depth = 8'(stored_count);
    return reply;
  endfunction

  // Presents one command and holds it until the block takes it. The command
  // is taken at the first rising edge at which busy is seen low while start
  // is high; the prediction is queued at that same edge. Start stays high
  // afterwards so a following command can go out back to back; it only
  // drops when the sender decides to idle.
  task automatic send_item(input logic [swds_pkg::OPCODE_W-1:0] op,
                           input logic [swds_pkg::WORD_W-1:0] word);
    while (idle_on && $urandom_range(99) < 18) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_opcode     <= op;
    in_push_value <= word;
    do @(posedge clk); while (busy);
    pending_replies.push_back(apply_command(op, word));
  endtask

  // Stops sending until every reply in flight has come back.
  task automatic wait_for_replies();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // Result checker. The receiver has no way to stall, so every cycle with
  // out_valid high is one reply that must match the oldest prediction.
  always @(posedge clk) begin
    stack_reply_t want;
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected reply word", out_read_value, '0);
      end else begin
        want = pending_replies.pop_front();
        if (out_read_value !== want.word)
          report_mismatch("read value", out_read_value, want.word);
        if (out_status !== want.status)
          report_mismatch("status", 64'(out_status), 64'(want.status));
        if (out_depth !== want.depth)
          report_mismatch("depth", 64'(out_depth), 64'(want.depth));
      end
      reply_count++;
    end
  end

  // Random word: mostly uniform, sometimes an extreme or a single set bit.
  function automatic logic [swds_pkg::WORD_W-1:0] random_word();
    logic [swds_pkg::WORD_W-1:0] w;
    case ($urandom_range(9))
      0:       w = '0;
      1:       w = '1;
      2:       w = 64'd1 << $urandom_range(swds_pkg::WORD_W-1);
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  // Picks an opcode with a bias that either builds the stack up or drains
  // it, so the random walk spends real time near both empty and full.
  function automatic logic [swds_pkg::OPCODE_W-1:0] random_opcode(input bit climbing);
    int unsigned r;
    logic [swds_pkg::OPCODE_W-1:0] op;
    r = $urandom_range(99);
    if (climbing) begin
      if (r < 50)       op = swds_pkg::OP_PUSH;
      else if (r < 60)  op = swds_pkg::OP_DUP;
      else if (r < 72)  op = swds_pkg::OP_POP;
      else if (r < 80)  op = swds_pkg::OP_PEEK;
      else if (r < 93)  op = swds_pkg::OP_SWAP;
      else if (r < 94)  op = swds_pkg::OP_CLEAR;
      else if (r < 95)  op = OP_SPARE_LO;
      else if (r < 96)  op = OP_SPARE_HI;
      else              op = swds_pkg::OP_PUSH;
    end else begin
      if (r < 50)       op = swds_pkg::OP_POP;
      else if (r < 62)  op = swds_pkg::OP_PUSH;
      else if (r < 72)  op = swds_pkg::OP_PEEK;
      else if (r < 84)  op = swds_pkg::OP_SWAP;
      else if (r < 92)  op = swds_pkg::OP_DUP;
      else if (r < 93)  op = swds_pkg::OP_CLEAR;
      else if (r < 94)  op = OP_SPARE_LO;
      else if (r < 95)  op = OP_SPARE_HI;
      else              op = swds_pkg::OP_POP;
    end
    return op;
  endfunction

  // Hand-picked commands: every refusal on an empty stack, both spare
  // opcodes, swap with a single entry, and word patterns at the extremes
  // (all zeros, all ones, an infinity pattern and a negative-zero pattern).
  task automatic test_directed_cases();
    send_item(swds_pkg::OP_POP,   '0);
    send_item(swds_pkg::OP_PEEK,  '1);
    send_item(swds_pkg::OP_DUP,   '0);
    send_item(swds_pkg::OP_SWAP,  '1);
    send_item(OP_SPARE_LO,        '0);
    send_item(OP_SPARE_HI,        '1);
    send_item(swds_pkg::OP_CLEAR, '0);
    send_item(swds_pkg::OP_PUSH,  64'h0000_0000_0000_0000);
    send_item(swds_pkg::OP_SWAP,  '0);
    send_item(swds_pkg::OP_DUP,   '0);
    send_item(swds_pkg::OP_PUSH,  64'hFFFF_FFFF_FFFF_FFFF);
    send_item(swds_pkg::OP_PEEK,  '0);
    send_item(swds_pkg::OP_SWAP,  '0);
    send_item(swds_pkg::OP_POP,   '0);
    send_item(swds_pkg::OP_POP,   '0);
    send_item(swds_pkg::OP_PUSH,  64'h7FF0_0000_0000_0000);
    send_item(swds_pkg::OP_PUSH,  64'h8000_0000_0000_0000);
    send_item(swds_pkg::OP_SWAP,  '0);
    send_item(OP_SPARE_HI,        64'h5555_5555_5555_5555);
    send_item(swds_pkg::OP_PEEK,  64'hAAAA_AAAA_AAAA_AAAA);
    send_item(swds_pkg::OP_CLEAR, '1);
    send_item(swds_pkg::OP_POP,   '0);
  endtask

  // Fills the stack to capacity with a mix of pushes and duplicates, pokes
  // at it while full (push, duplicate, swap and peek), then pops every entry
  // back out and finishes with a pop on the empty stack.
  task automatic test_fill_to_capacity();
    send_item(swds_pkg::OP_CLEAR, '0);
    while (stored_count < CAPACITY) begin
      if (stored_count > 0 && $urandom_range(7) == 0)
        send_item(swds_pkg::OP_DUP, random_word());
      else
        send_item(swds_pkg::OP_PUSH, random_word());
    end
    send_item(swds_pkg::OP_PUSH, random_word());
    send_item(swds_pkg::OP_DUP,  random_word());
    send_item(swds_pkg::OP_SWAP, random_word());
    send_item(swds_pkg::OP_PEEK, random_word());
    while (stored_count > 0) begin
      if ($urandom_range(9) == 0)
        send_item(swds_pkg::OP_SWAP, random_word());
      send_item(swds_pkg::OP_POP, random_word());
    end
    send_item(swds_pkg::OP_POP, random_word());
  endtask

  // Biased random walk over all opcodes. The direction flips now and then
  // once the stack sits at full or at empty, so both ends get visited
  // repeatedly with plenty of commands applied right at the boundary.
  task automatic test_random_walk(input int unsigned count);
    bit climbing;
    climbing = 1'b1;
    repeat (count) begin
      if (stored_count == CAPACITY && $urandom_range(5) == 0)
        climbing = 1'b0;
      else if (stored_count == 0 && $urandom_range(3) == 0)
        climbing = 1'b1;
      send_item(random_opcode(climbing), random_word());
    end
  endtask

  // Random commands in short bursts, with the sender going quiet after each
  // burst until every reply is back, so the block is restarted from idle.
  task automatic test_pause_and_resume(input int unsigned bursts);
    repeat (bursts) begin
      repeat ($urandom_range(3, 12))
        send_item(random_opcode(1'($urandom_range(1))), random_word());
      wait_for_replies();
    end
  endtask

  initial begin
    int unsigned waited;
    start         <= 1'b0;
    in_opcode     <= swds_pkg::OP_PUSH;
    in_push_value <= '0;
    rst_n         <= 1'b0;
    cycle_count   = 0;
    error_count   = 0;
    reply_count   = 0;
    stored_count  = 0;
    idle_on       = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_fill_to_capacity();
    test_random_walk(450);
    // A long stretch with start never dropped between commands.
    idle_on = 1'b0;
    test_random_walk(250);
    idle_on = 1'b1;
    test_pause_and_resume(20);
    test_random_walk(250);

    // Drain: every prediction must be answered within a short window, and
    // a final wait catches any stray reply that follows.
    start  <= 1'b0;
    waited = 0;
    while (pending_replies.size() != 0 && waited < 64) begin
      @(posedge clk);
      waited++;
    end
    if (pending_replies.size() != 0)
      report_mismatch("count of missing replies", 64'(pending_replies.size()), '0);
    repeat (8) @(posedge clk);

    if (error_count == 0) begin
      $display("stack_with_dup_swap: match");
    end else begin
      $display("stack_with_dup_swap: mismatch");
    end
    $finish;
  end

endmodule
